/* sv/slr_pkg.sv */
// Package with shared types, constants and helper functions of the link retry block.
package slr_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned FrameW     = 8 * FrameBytes;
  localparam int unsigned PayloadW   = 56;
  localparam int unsigned CntW       = 16;
  localparam int unsigned SeqW       = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdSubmit = 2'd1;
  localparam logic [1:0] CmdTake   = 2'd2;

  localparam logic [1:0] FaultNone  = 2'd0;
  localparam logic [1:0] FaultNoAck = 2'd1;
  localparam logic [1:0] FaultTxErr = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgPacketLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaitLimit    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRetryLimit   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgQuietWindow  = 2'd3;

  localparam logic [2:0]      RstPacketLength = 3'd7;
  localparam logic [CntW-1:0] RstWaitLimit    = 16'd10;
  localparam logic [CntW-1:0] RstRetryLimit   = 16'd4;
  localparam logic [CntW-1:0] RstQuietWindow  = 16'(110 * 2 + 12 + 32);
  localparam logic [SeqW-1:0] RstLastSeq      = 8'hAA;
  localparam logic [CntW-1:0] CntMax          = '1;

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhStart = 4'b0010,
    PhBusy  = 4'b0100,
    PhFault = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [2:0]      packet_length;
    logic [CntW-1:0] wait_limit;
    logic [CntW-1:0] retry_limit;
    logic [CntW-1:0] quiet_window;
  } cfg_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] cmd;
  } step_t;

  // Mask covering the low n bytes of a frame; n of eight or more covers all.
  function automatic logic [FrameW-1:0] byte_mask(input logic [3:0] n);
    logic [FrameW-1:0] m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [2:0] eff_len(input logic [2:0] pl);
    logic [2:0] lim;
    lim = 3'(FrameBytes - 1);
    return (pl < lim) ? pl : lim;
  endfunction

  function automatic logic [FrameW-1:0] make_frame(input logic [PayloadW-1:0] store,
                                                   input logic [2:0] len,
                                                   input logic [SeqW-1:0] seq);
    logic [FrameW-1:0] f;
    f = ({8'd0, store} & byte_mask({1'b0, len})) | ({56'd0, seq} << {len, 3'b000});
    return f;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + 16'd1;
  endfunction

endpackage

/* sv/slr_rx.sv */
// Receive path: stores incoming frames, filters repeated sequence bytes, hands back payloads.
module slr_rx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slr_pkg::step_t                step_i,
  input  logic [2:0]                    len_i,
  input  logic                          rx_valid_i,
  input  logic [slr_pkg::FrameW-1:0]    rx_frame_i,
  output logic                          pending_o,
  output logic [slr_pkg::PayloadW-1:0]  rx_data_o
);

  logic [slr_pkg::FrameW-1:0] in_store_q, in_store_d;
  logic [slr_pkg::SeqW-1:0]   last_seq_q, last_seq_d;
  logic                       pending_q, pending_d;
  logic [slr_pkg::FrameW-1:0] rx_mask;
  logic [slr_pkg::FrameW-1:0] rx_shift;
  logic [slr_pkg::FrameW-1:0] take_data;

  // The mask reaches one byte past the payload to include the sequence byte.
  assign rx_mask   = slr_pkg::byte_mask({1'b0, len_i} + 4'd1);
  assign rx_shift  = rx_frame_i >> {len_i, 3'b000};
  assign take_data = in_store_q & slr_pkg::byte_mask({1'b0, len_i});

  always_comb begin
    in_store_d = in_store_q;
    last_seq_d = last_seq_q;
    pending_d  = pending_q;
    rx_data_o  = '0;
    if (step_i.fire) begin
      if (step_i.cmd == slr_pkg::CmdTake) begin
        rx_data_o = take_data[slr_pkg::PayloadW-1:0];
        pending_d = 1'b0;
      end else if (step_i.cmd == slr_pkg::CmdTick && rx_valid_i) begin
        in_store_d = (in_store_q & ~rx_mask) | (rx_frame_i & rx_mask);
        if (rx_shift[slr_pkg::SeqW-1:0] != last_seq_q) begin
          last_seq_d = rx_shift[slr_pkg::SeqW-1:0];
          pending_d  = 1'b1;
        end
      end
    end
  end

  assign pending_o = pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_store_q <= '0;
      last_seq_q <= slr_pkg::RstLastSeq;
      pending_q  <= 1'b0;
    end else begin
      in_store_q <= in_store_d;
      last_seq_q <= last_seq_d;
      pending_q  <= pending_d;
    end
  end

endmodule

/* sv/slr_tx.sv */
// Send path: phase machine with sequence stamping, timeout, retry counting and fault latch.
module slr_tx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slr_pkg::step_t                step_i,
  input  slr_pkg::cfg_t                 cfg_i,
  input  logic [2:0]                    len_i,
  input  logic [slr_pkg::PayloadW-1:0]  tx_payload_i,
  input  logic                          tx_done_i,
  input  logic                          tx_failed_i,
  input  logic [15:0]                   period_time_i,
  input  logic [15:0]                   cycle_time_i,
  output logic                          idle_o,
  output logic                          tx_start_o,
  output logic                          tx_abort_o,
  output logic [slr_pkg::FrameW-1:0]    tx_frame_o,
  output logic [1:0]                    fault_o
);

  slr_pkg::phase_e phase_q, phase_d;
  logic [slr_pkg::PayloadW-1:0] store_q, store_d;
  logic [slr_pkg::CntW-1:0]     wait_q, wait_d, retry_q, retry_d;
  logic [slr_pkg::CntW-1:0]     wait_inc, retry_inc;
  logic [slr_pkg::SeqW-1:0]     seq_q, seq_d;
  logic [1:0]                   fcode_q, fcode_d;
  logic [15:0]                  remain;

  assign remain    = (period_time_i > cycle_time_i) ? period_time_i - cycle_time_i : 16'd0;
  assign wait_inc  = slr_pkg::sat_inc(wait_q);
  assign retry_inc = slr_pkg::sat_inc(retry_q);

  always_comb begin
    phase_d    = phase_q;
    store_d    = store_q;
    wait_d     = wait_q;
    retry_d    = retry_q;
    seq_d      = seq_q;
    fcode_d    = fcode_q;
    tx_start_o = 1'b0;
    tx_abort_o = 1'b0;
    tx_frame_o = '0;
    fault_o    = slr_pkg::FaultNone;
    if (step_i.fire) begin
      if (step_i.cmd == slr_pkg::CmdSubmit) begin
        if (phase_q != slr_pkg::PhFault) begin
          store_d = tx_payload_i;
          phase_d = slr_pkg::PhStart;
        end
      end else if (step_i.cmd == slr_pkg::CmdTick) begin
        unique case (phase_q)
          slr_pkg::PhStart: begin
            if (remain > cfg_i.quiet_window) begin
              tx_start_o = 1'b1;
              tx_frame_o = slr_pkg::make_frame(store_q, len_i, seq_q);
              seq_d      = seq_q + 8'd1;
              wait_d     = '0;
              retry_d    = '0;
              phase_d    = slr_pkg::PhBusy;
            end
          end
          slr_pkg::PhBusy: begin
            // Restarts resend the frame with the sequence byte of the first attempt.
            if (tx_done_i) begin
              if (!tx_failed_i) begin
                phase_d = slr_pkg::PhIdle;
              end else begin
                retry_d = retry_inc;
                if (retry_inc >= cfg_i.retry_limit) begin
                  fcode_d = slr_pkg::FaultTxErr;
                  phase_d = slr_pkg::PhFault;
                end else begin
                  tx_start_o = 1'b1;
                  tx_frame_o = slr_pkg::make_frame(store_q, len_i, seq_q - 8'd1);
                  wait_d     = '0;
                end
              end
            end else begin
              wait_d = wait_inc;
              if (wait_inc >= cfg_i.wait_limit) begin
                retry_d = retry_inc;
                if (retry_inc >= cfg_i.retry_limit) begin
                  fcode_d = slr_pkg::FaultNoAck;
                  phase_d = slr_pkg::PhFault;
                end else begin
                  tx_abort_o = 1'b1;
                  tx_start_o = 1'b1;
                  tx_frame_o = slr_pkg::make_frame(store_q, len_i, seq_q - 8'd1);
                  wait_d     = '0;
                end
              end
            end
          end
          slr_pkg::PhIdle, slr_pkg::PhFault: begin
          end
          default: begin
          end
        endcase
        if (phase_d == slr_pkg::PhFault) begin
          fault_o = fcode_d;
        end
      end
    end
  end

  assign idle_o = (phase_d == slr_pkg::PhIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slr_pkg::PhIdle;
      store_q <= '0;
      wait_q  <= '0;
      retry_q <= '0;
      seq_q   <= '0;
      fcode_q <= slr_pkg::FaultNone;
    end else begin
      phase_q <= phase_d;
      store_q <= store_d;
      wait_q  <= wait_d;
      retry_q <= retry_d;
      seq_q   <= seq_d;
      fcode_q <= fcode_d;
    end
  end

endmodule

/* sv/seq_numbered_link_retry_top.sv */
// Top level of the sequence-numbered link retry block: handshakes, configuration, result register.
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the result register lets a new item in while it is taken.
// A stalled result holds the item channel only until the result register is taken.
// Reset (asynchronous, active low) restores the configuration defaults, idles the sender,
// clears stores, counters and fault, and sets the last seen sequence byte to 0xAA.
module seq_numbered_link_retry_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [slr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [slr_pkg::PayloadW-1:0]  tx_payload_i,
  input  logic                          rx_valid_i,
  input  logic [slr_pkg::FrameW-1:0]    rx_frame_i,
  input  logic                          tx_done_i,
  input  logic                          tx_failed_i,
  input  logic [15:0]                   period_time_i,
  input  logic [15:0]                   cycle_time_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          in_ready_o,
  output logic                          out_ready_o,
  output logic [slr_pkg::PayloadW-1:0]  rx_data_o,
  output logic                          tx_start_o,
  output logic                          tx_abort_o,
  output logic [slr_pkg::FrameW-1:0]    tx_frame_o,
  output logic [1:0]                    fault_o
);

  slr_pkg::cfg_t  cfg_q;
  slr_pkg::step_t step;
  logic [2:0]     len;
  logic           res_valid_q;

  logic                         pending;
  logic [slr_pkg::PayloadW-1:0] rx_data;
  logic                         idle;
  logic                         start;
  logic                         abort_tx;
  logic [slr_pkg::FrameW-1:0]   frame;
  logic [1:0]                   fault;

  logic                         in_ready_q;
  logic                         out_ready_q;
  logic [slr_pkg::PayloadW-1:0] rx_data_q;
  logic                         tx_start_q;
  logic                         tx_abort_q;
  logic [slr_pkg::FrameW-1:0]   tx_frame_q;
  logic [1:0]                   fault_q;

  assign cfg_ready_o  = 1'b1;
  assign item_ready_o = !res_valid_q || res_ready_i;
  assign step.fire    = item_valid_i && item_ready_o;
  assign step.cmd     = cmd_i;
  assign len          = slr_pkg::eff_len(cfg_q.packet_length);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_length <= slr_pkg::RstPacketLength;
      cfg_q.wait_limit    <= slr_pkg::RstWaitLimit;
      cfg_q.retry_limit   <= slr_pkg::RstRetryLimit;
      cfg_q.quiet_window  <= slr_pkg::RstQuietWindow;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        slr_pkg::CfgPacketLength: cfg_q.packet_length <= cfg_data_i[2:0];
        slr_pkg::CfgWaitLimit:    cfg_q.wait_limit    <= cfg_data_i;
        slr_pkg::CfgRetryLimit:   cfg_q.retry_limit   <= cfg_data_i;
        slr_pkg::CfgQuietWindow:  cfg_q.quiet_window  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  slr_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .len_i      (len),
    .rx_valid_i (rx_valid_i),
    .rx_frame_i (rx_frame_i),
    .pending_o  (pending),
    .rx_data_o  (rx_data)
  );

  slr_tx u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .cfg_i         (cfg_q),
    .len_i         (len),
    .tx_payload_i  (tx_payload_i),
    .tx_done_i     (tx_done_i),
    .tx_failed_i   (tx_failed_i),
    .period_time_i (period_time_i),
    .cycle_time_i  (cycle_time_i),
    .idle_o        (idle),
    .tx_start_o    (start),
    .tx_abort_o    (abort_tx),
    .tx_frame_o    (frame),
    .fault_o       (fault)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      res_valid_q <= step.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire) begin
      in_ready_q  <= pending;
      out_ready_q <= idle;
      rx_data_q   <= rx_data;
      tx_start_q  <= start;
      tx_abort_q  <= abort_tx;
      tx_frame_q  <= frame;
      fault_q     <= fault;
    end
  end

  assign res_valid_o = res_valid_q;
  assign in_ready_o  = in_ready_q;
  assign out_ready_o = out_ready_q;
  assign rx_data_o   = rx_data_q;
  assign tx_start_o  = tx_start_q;
  assign tx_abort_o  = tx_abort_q;
  assign tx_frame_o  = tx_frame_q;
  assign fault_o     = fault_q;

`ifndef ASSERT_OFF
  // An abort is always followed by a restart in the same transaction.
  a_abort_with_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && tx_abort_o |-> tx_start_o)
    else $error("tx_abort without tx_start");

  // A reported fault means the sender is not idle.
  a_fault_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (fault_o != slr_pkg::FaultNone) |-> !out_ready_o)
    else $error("fault reported while sender idle");

  // A frame is only presented together with a start command.
  a_frame_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !tx_start_o |-> (tx_frame_o == '0))
    else $error("tx_frame nonzero without tx_start");

  // A start cannot coincide with a fault report.
  a_start_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && tx_start_o |-> (fault_o == slr_pkg::FaultNone))
    else $error("tx_start together with fault");
`endif

endmodule
